>>> design/prxyz_pkg.sv
// shared types, constants and the round/saturate function for the point rotation core
// no dependencies; imported by prxyz_turn, point_rotate_xyz_core and the testbench
`timescale 1ns / 1ps

package prxyz_pkg;

  localparam int COORD_W = 32;
  localparam int TRIG_W  = 16;
  localparam int FRAC_W  = 14;
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int RND_W   = SUM_W + 1;
  localparam int QUO_W   = RND_W - FRAC_W;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 16'sd16384;
  localparam logic signed [TRIG_W-1:0] TRIG_ZERO = 16'sd0;
  localparam logic signed [RND_W-1:0]  HALF_LSB  = RND_W'(signed'(8192));
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_X = 3'd0,
    REG_SIN_X = 3'd1,
    REG_COS_Y = 3'd2,
    REG_SIN_Y = 3'd3,
    REG_COS_Z = 3'd4,
    REG_SIN_Z = 3'd5
  } cfg_reg_t;

  // one plane turn: a and b are rotated, keep rides along untouched
  typedef struct packed {
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] keep;
    logic                      clip;
  } turn_data_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] c;
    logic signed [TRIG_W-1:0] s;
  } trig_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] value;
    logic                      clip;
  } sat_t;

  // round to nearest (ties up), floor shift by 2^14, saturate to 32 bits
  function automatic sat_t round_sat(input logic signed [SUM_W-1:0] sum);
    logic signed [RND_W-1:0] v;
    logic signed [QUO_W-1:0] q;
    sat_t                    r;
    v = RND_W'(sum) + HALF_LSB;
    q = v[RND_W-1:FRAC_W];
    if (q[QUO_W-1:COORD_W-1] == '0 || q[QUO_W-1:COORD_W-1] == '1) begin
      r.value = q[COORD_W-1:0];
      r.clip  = 1'b0;
    end else begin
      r.value = q[QUO_W-1] ? COORD_MIN : COORD_MAX;
      r.clip  = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> design/point_rotate_xyz_core.sv
// pipeline from input transaction to result: two register stages per rotation axis
// throughput: one point per cycle unless stalled; each unit holds a multiply stage
// and a round/saturate stage, and each stage stalls only when its successor is full
// reset: synchronous, active high; empties the pipeline and loads cos = 1.0, sin = 0
// depends on prxyz_pkg and prxyz_turn
`timescale 1ns / 1ps

module point_rotate_xyz_core (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [prxyz_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prxyz_pkg::TRIG_W-1:0]      cfg_data,
  // input points
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // in_x [31:0], in_y [63:32], in_z [95:64]
  // rotated points
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
  output logic [0:0]  m_tuser    // clipped [0]
);
  import prxyz_pkg::*;

  trig_t trig_x;
  trig_t trig_y;
  trig_t trig_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_x <= '{c: TRIG_ONE, s: TRIG_ZERO};
      trig_y <= '{c: TRIG_ONE, s: TRIG_ZERO};
      trig_z <= '{c: TRIG_ONE, s: TRIG_ZERO};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COS_X: trig_x.c <= cfg_data;
        REG_SIN_X: trig_x.s <= cfg_data;
        REG_COS_Y: trig_y.c <= cfg_data;
        REG_SIN_Y: trig_y.s <= cfg_data;
        REG_COS_Z: trig_z.c <= cfg_data;
        REG_SIN_Z: trig_z.s <= cfg_data;
        default: ;
      endcase
    end
  end

  turn_data_t x_in, x_out, y_in, y_out, z_in, z_out;
  logic       x_out_valid, y_out_valid, z_out_valid;
  logic       x_out_ready, y_out_ready;

  // about x: (a, b) = (y, z)
  assign x_in.a    = s_tdata[63:32];
  assign x_in.b    = s_tdata[95:64];
  assign x_in.keep = s_tdata[31:0];
  assign x_in.clip = 1'b0;

  prxyz_turn u_turn_x (
    .clk       (clk),
    .rst       (rst),
    .trig      (trig_x),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (x_in),
    .out_valid (x_out_valid),
    .out_ready (x_out_ready),
    .out_data  (x_out)
  );

  // about y: (a, b) = (z, x)
  assign y_in.a    = x_out.b;
  assign y_in.b    = x_out.keep;
  assign y_in.keep = x_out.a;
  assign y_in.clip = x_out.clip;

  prxyz_turn u_turn_y (
    .clk       (clk),
    .rst       (rst),
    .trig      (trig_y),
    .in_valid  (x_out_valid),
    .in_ready  (x_out_ready),
    .in_data   (y_in),
    .out_valid (y_out_valid),
    .out_ready (y_out_ready),
    .out_data  (y_out)
  );

  // about z: (a, b) = (x, y)
  assign z_in.a    = y_out.b;
  assign z_in.b    = y_out.keep;
  assign z_in.keep = y_out.a;
  assign z_in.clip = y_out.clip;

  prxyz_turn u_turn_z (
    .clk       (clk),
    .rst       (rst),
    .trig      (trig_z),
    .in_valid  (y_out_valid),
    .in_ready  (y_out_ready),
    .in_data   (z_in),
    .out_valid (z_out_valid),
    .out_ready (m_tready),
    .out_data  (z_out)
  );

  assign m_tvalid = z_out_valid;
  assign m_tdata  = {z_out.keep, z_out.b, z_out.a};
  assign m_tuser  = z_out.clip;

endmodule

>>> design/prxyz_turn.sv
// one plane rotation: a multiply stage then a sum, round and saturate stage
// depends on prxyz_pkg
`timescale 1ns / 1ps

module prxyz_turn (
  input  logic                 clk,
  input  logic                 rst,
  input  prxyz_pkg::trig_t     trig,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prxyz_pkg::turn_data_t in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prxyz_pkg::turn_data_t out_data
);
  import prxyz_pkg::*;

  // multiply stage
  logic                      mul_valid;
  logic signed [PROD_W-1:0]  prod_ac;
  logic signed [PROD_W-1:0]  prod_bs;
  logic signed [PROD_W-1:0]  prod_as;
  logic signed [PROD_W-1:0]  prod_bc;
  logic signed [COORD_W-1:0] mul_keep;
  logic                      mul_clip;

  // result stage
  logic       res_valid;
  turn_data_t res_data;

  logic mul_ready;
  logic res_ready;
  sat_t new_a;
  sat_t new_b;

  // a stage moves on when empty or when its successor takes its transaction
  assign res_ready = !res_valid || out_ready;
  assign mul_ready = !mul_valid || res_ready;
  assign in_ready  = mul_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_ready) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_ready && in_valid) begin
      prod_ac  <= in_data.a * trig.c;
      prod_bs  <= in_data.b * trig.s;
      prod_as  <= in_data.a * trig.s;
      prod_bc  <= in_data.b * trig.c;
      mul_keep <= in_data.keep;
      mul_clip <= in_data.clip;
    end
  end

  always_comb begin
    new_a = round_sat(SUM_W'(prod_ac) - SUM_W'(prod_bs));
    new_b = round_sat(SUM_W'(prod_as) + SUM_W'(prod_bc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_ready) begin
      res_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && mul_valid) begin
      res_data.a    <= new_a.value;
      res_data.b    <= new_b.value;
      res_data.keep <= mul_keep;
      res_data.clip <= mul_clip | new_a.clip | new_b.clip;
    end
  end

  assign out_valid = res_valid;
  assign out_data  = res_data;

endmodule

>>> tb/point_rotate_scoreboard.sv
// scoreboard for point_rotate_xyz_core: tracks register writes, predicts each rotated point
// and compares the result stream in order; depends on prxyz_pkg for widths and register codes
`timescale 1ns / 1ps

module point_rotate_scoreboard (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [prxyz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [prxyz_pkg::TRIG_W-1:0]    cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [95:0]                     s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [95:0]                     m_tdata,
  input  logic [0:0]                      m_tuser,
  output int                              errors,
  output int                              backlog
);
  import prxyz_pkg::*;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic               clip;
  } rotated_t;

  logic signed [TRIG_W-1:0] cos_x = TRIG_ONE, sin_x = TRIG_ZERO;
  logic signed [TRIG_W-1:0] cos_y = TRIG_ONE, sin_y = TRIG_ZERO;
  logic signed [TRIG_W-1:0] cos_z = TRIG_ONE, sin_z = TRIG_ZERO;

  rotated_t rotated_due[$];
  int       mismatch_count = 0;

  assign errors  = mismatch_count;
  assign backlog = rotated_due.size();

  // half-up rounding then floor division by 2^14, clamped to the coordinate range
  function automatic longint round_clamp(input longint sum, inout bit clip);
    longint q;
    q = (sum + 64'sd8192) >>> FRAC_W;
    if (q > longint'(COORD_MAX)) begin
      clip = 1'b1;
      q = longint'(COORD_MAX);
    end else if (q < longint'(COORD_MIN)) begin
      clip = 1'b1;
      q = longint'(COORD_MIN);
    end
    return q;
  endfunction

  function automatic void plane_turn(inout longint a, inout longint b,
                                     input longint c, input longint s, inout bit clip);
    longint na, nb;
    na = round_clamp(a * c - b * s, clip);
    nb = round_clamp(a * s + b * c, clip);
    a = na;
    b = nb;
  endfunction

  function automatic rotated_t rotate_point(input logic [95:0] d);
    longint   x, y, z;
    bit       clip;
    rotated_t r;
    x = longint'(signed'(d[31:0]));
    y = longint'(signed'(d[63:32]));
    z = longint'(signed'(d[95:64]));
    clip = 1'b0;
    plane_turn(y, z, longint'(cos_x), longint'(sin_x), clip);
    // the y axis turn acts on (z, x) in that order
    plane_turn(z, x, longint'(cos_y), longint'(sin_y), clip);
    plane_turn(x, y, longint'(cos_z), longint'(sin_z), clip);
    r.x    = x[31:0];
    r.y    = y[31:0];
    r.z    = z[31:0];
    r.clip = clip;
    return r;
  endfunction

  always @(posedge clk) begin
    rotated_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_COS_X: cos_x = cfg_data;
          REG_SIN_X: sin_x = cfg_data;
          REG_COS_Y: cos_y = cfg_data;
          REG_SIN_Y: sin_y = cfg_data;
          REG_COS_Z: cos_z = cfg_data;
          REG_SIN_Z: sin_z = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        rotated_due.push_back(rotate_point(s_tdata));
      if (m_tvalid && m_tready) begin
        if (rotated_due.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result x=%h y=%h z=%h clip=%b", $realtime,
                     m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]);
          mismatch_count++;
        end else begin
          want = rotated_due.pop_front();
          if (m_tdata[31:0] !== want.x || m_tdata[63:32] !== want.y ||
              m_tdata[95:64] !== want.z || m_tuser[0] !== want.clip) begin
            if (mismatch_count < 10)
              $display("%0t: expected x=%h y=%h z=%h clip=%b, got x=%h y=%h z=%h clip=%b",
                       $realtime, want.x, want.y, want.z, want.clip,
                       m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tuser[0]);
            mismatch_count++;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb_point_rotate_xyz_core.sv
// top of the point rotation testbench: clock, reset, register writes, point stimulus
// and output back-pressure; depends on prxyz_pkg, point_rotate_xyz_core, point_rotate_scoreboard
`timescale 1ns / 1ps

module tb_point_rotate_xyz_core;
  import prxyz_pkg::*;

  // indexes past the last register, writes there must have no effect
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic signed [TRIG_W-1:0] TRIG_NEG_ONE = -16'sd16384;
  localparam logic signed [TRIG_W-1:0] TRIG_FLOOR   = 16'sh8000;
  localparam logic signed [TRIG_W-1:0] TRIG_CEIL    = 16'sh7fff;
  localparam logic signed [TRIG_W-1:0] TRIG_HALF_RT = 16'sd11585;

  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 116;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int DRAIN_CYCLES    = 10;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TRIG_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [95:0]          s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [95:0]          m_tdata;
  logic [0:0]           m_tuser;

  int errors;
  int backlog;
  bit quiet = 1'b0;
  bit choke_now = 1'b0;
  bit burst_mode = 1'b0;

  point_rotate_xyz_core dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  point_rotate_scoreboard scoreboard (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .backlog  (backlog)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [95:0] pack_point(input logic [31:0] x, input logic [31:0] y,
                                             input logic [31:0] z);
    return {z, y, x};
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'(int'($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000);
      3: begin
        case ($urandom_range(0, 4))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          default: return 32'd1;
        endcase
      end
      default: return 32'(int'($urandom_range(0, 32'h1fff_ffff)) - 32'sh1000_0000);
    endcase
  endfunction

  function automatic logic [TRIG_W-1:0] pick_trig();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 5))
          0: return TRIG_ONE;
          1: return TRIG_NEG_ONE;
          2: return TRIG_ZERO;
          3: return TRIG_FLOOR;
          4: return TRIG_CEIL;
          default: return TRIG_HALF_RT;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TRIG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // let the pipeline empty before touching the angle registers
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (backlog == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_angles(input logic [TRIG_W-1:0] cx, input logic [TRIG_W-1:0] sx,
                            input logic [TRIG_W-1:0] cy, input logic [TRIG_W-1:0] sy,
                            input logic [TRIG_W-1:0] cz, input logic [TRIG_W-1:0] sz);
    drain();
    write_reg(REG_COS_X, cx);
    write_reg(REG_SIN_X, sx);
    write_reg(REG_COS_Y, cy);
    write_reg(REG_SIN_Y, sy);
    write_reg(REG_COS_Z, cz);
    write_reg(REG_SIN_Z, sz);
  endtask

  task automatic offer_point(input logic [95:0] d);
    int gap;
    if (!quiet && !burst_mode && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // output side back-pressure
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (choke_now) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        choke_now = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // identity rotation straight out of reset
    offer_point(pack_point(32'd0, 32'd0, 32'd0));
    offer_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX));
    offer_point(pack_point(COORD_MIN, COORD_MIN, COORD_MIN));
    offer_point(pack_point(32'hffff_ffff, 32'd1, COORD_MIN));
    offer_point(pack_point(32'h0001_0000, 32'hfffe_8000, 32'h7fff_0000));

    // spare indexes are ignored, so the reset angles must still hold
    drain();
    write_reg(REG_SPARE_LO, 16'h1234);
    write_reg(REG_SPARE_HI, 16'hbeef);
    offer_point(pack_point(32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f));

    // oversized sine and cosine, saturation on every axis
    set_angles(TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE);
    offer_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX));
    offer_point(pack_point(COORD_MIN, COORD_MIN, COORD_MIN));
    offer_point(pack_point(COORD_MAX, COORD_MIN, COORD_MAX));

    // most negative register pattern, outside the nominal range
    set_angles(TRIG_FLOOR, TRIG_FLOOR, TRIG_FLOOR, TRIG_FLOOR, TRIG_FLOOR, TRIG_FLOOR);
    offer_point(pack_point(COORD_MAX, COORD_MAX, COORD_MAX));
    offer_point(pack_point(COORD_MIN, COORD_MIN, COORD_MIN));
    offer_point(pack_point(32'd1, 32'hffff_ffff, 32'd0));
    offer_point(pack_point(32'h0000_2000, 32'hffff_e000, 32'h0000_6000));

    // half turns and quarter turns
    set_angles(TRIG_NEG_ONE, TRIG_ZERO, TRIG_ZERO, TRIG_ONE, TRIG_ZERO, TRIG_NEG_ONE);
    offer_point(pack_point(COORD_MIN, COORD_MAX, 32'd3));
    offer_point(pack_point(32'd1, 32'd2, 32'hffff_ffff));
    offer_point(pack_point(COORD_MIN, COORD_MIN, COORD_MAX));

    set_angles(TRIG_HALF_RT, TRIG_HALF_RT, TRIG_CEIL, TRIG_NEG_ONE, TRIG_HALF_RT, TRIG_CEIL);
    offer_point(pack_point(32'd1, 32'd1, 32'd1));
    offer_point(pack_point(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    offer_point(pack_point(COORD_MAX, 32'd0, COORD_MIN));
    offer_point(pack_point(32'h4000_0000, 32'hc000_0000, 32'h2000_0000));

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0)
        set_angles(TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO, TRIG_ONE, TRIG_ZERO);
      else
        set_angles(pick_trig(), pick_trig(), pick_trig(), pick_trig(), pick_trig(),
                   pick_trig());
      if (phase == 3)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
      quiet = (phase == 4) || (phase == PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // long receiver hold-off while points keep coming back to back
        if (phase == 2 && n == 0) begin
          burst_mode = 1'b1;
          choke_now = 1'b1;
        end
        if (phase == 2 && n == 40)
          burst_mode = 1'b0;
        offer_point(pack_point(pick_coord(), pick_coord(), pick_coord()));
      end
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (backlog == 0);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
